/* src/text_encoding_detector_core_assert.svh */
// Assertion macros used by the checker module of this block.
`ifndef TEXT_ENCODING_DETECTOR_CORE_ASSERT_SVH
`define TEXT_ENCODING_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define TED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define TED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define TED_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/ted_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ted_pkg;

    localparam logic       CMD_DATA = 1'b0;
    localparam logic       CMD_END  = 1'b1;

    localparam logic [2:0] ENC_UTF8     = 3'd0;
    localparam logic [2:0] ENC_UTF8_BOM = 3'd1;
    localparam logic [2:0] ENC_UTF16_LE = 3'd2;
    localparam logic [2:0] ENC_UTF16_BE = 3'd3;
    localparam logic [2:0] ENC_ASCII    = 3'd4;
    localparam logic [2:0] ENC_UNKNOWN  = 3'd5;

    localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
    localparam logic [7:0] MASK_TOP2      = 8'hC0;
    localparam logic [7:0] MASK_TOP3      = 8'hE0;
    localparam logic [7:0] MASK_TOP4      = 8'hF0;
    localparam logic [7:0] MASK_TOP5      = 8'hF8;
    localparam logic [7:0] PAT_CONT       = 8'h80;
    localparam logic [7:0] PAT_LEAD2      = 8'hC0;
    localparam logic [7:0] PAT_LEAD3      = 8'hE0;
    localparam logic [7:0] PAT_LEAD4      = 8'hF0;
    localparam logic [7:0] BOM8_B0        = 8'hEF;
    localparam logic [7:0] BOM8_B1        = 8'hBB;
    localparam logic [7:0] BOM8_B2        = 8'hBF;
    localparam logic [7:0] BOM16_FF       = 8'hFF;
    localparam logic [7:0] BOM16_FE       = 8'hFE;

    typedef struct packed {
        logic take;
        logic finish;
    } t_step;

endpackage

`default_nettype wire

/* src/ted_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module ted_scan
    import ted_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_step      i_step,
    input  wire logic [7:0] i_byte_value,
    output logic      [2:0] o_encoding
);

    logic [1:0] r_bytes_seen, n_bytes_seen;
    logic [7:0] r_first_byte, n_first_byte;
    logic [7:0] r_second_byte, n_second_byte;
    logic       r_mark_found, n_mark_found;
    logic       r_saw_high, n_saw_high;
    logic       r_broken, n_broken;
    logic [1:0] r_pending, n_pending;
    logic       is_high;

    assign is_high = (i_byte_value > BYTE_ASCII_MAX);

    always_comb begin
        n_bytes_seen  = r_bytes_seen;
        n_first_byte  = r_first_byte;
        n_second_byte = r_second_byte;
        n_mark_found  = r_mark_found;
        n_saw_high    = r_saw_high;
        n_broken      = r_broken;
        n_pending     = r_pending;
        if (i_step.finish) begin
            n_bytes_seen  = 2'd0;
            n_first_byte  = 8'h00;
            n_second_byte = 8'h00;
            n_mark_found  = 1'b0;
            n_saw_high    = 1'b0;
            n_broken      = 1'b0;
            n_pending     = 2'd0;
        end else if (i_step.take) begin
            case (r_bytes_seen)
                2'd0: n_first_byte = i_byte_value;
                2'd1: n_second_byte = i_byte_value;
                2'd2: n_mark_found = (r_first_byte == BOM8_B0) && (r_second_byte == BOM8_B1)
                                     && (i_byte_value == BOM8_B2);
                default: ;
            endcase
            if (r_bytes_seen != 2'd3) begin
                n_bytes_seen = r_bytes_seen + 2'd1;
            end
            if (is_high) begin
                n_saw_high = 1'b1;
            end
            if (r_pending != 2'd0) begin
                if ((i_byte_value & MASK_TOP2) != PAT_CONT) begin
                    n_broken = 1'b1;
                end
                n_pending = r_pending - 2'd1;
            end else if (!is_high) begin
                n_pending = 2'd0;
            end else if ((i_byte_value & MASK_TOP3) == PAT_LEAD2) begin
                n_pending = 2'd1;
            end else if ((i_byte_value & MASK_TOP4) == PAT_LEAD3) begin
                n_pending = 2'd2;
            end else if ((i_byte_value & MASK_TOP5) == PAT_LEAD4) begin
                n_pending = 2'd3;
            end else begin
                n_broken = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen  <= 2'd0;
            r_first_byte  <= 8'h00;
            r_second_byte <= 8'h00;
            r_mark_found  <= 1'b0;
            r_saw_high    <= 1'b0;
            r_broken      <= 1'b0;
            r_pending     <= 2'd0;
        end else begin
            r_bytes_seen  <= n_bytes_seen;
            r_first_byte  <= n_first_byte;
            r_second_byte <= n_second_byte;
            r_mark_found  <= n_mark_found;
            r_saw_high    <= n_saw_high;
            r_broken      <= n_broken;
            r_pending     <= n_pending;
        end
    end

    always_comb begin
        if (r_bytes_seen == 2'd0) begin
            o_encoding = ENC_UTF8;
        end else if (r_mark_found) begin
            o_encoding = ENC_UTF8_BOM;
        end else if ((r_bytes_seen != 2'd1) && (r_first_byte == BOM16_FF)
                     && (r_second_byte == BOM16_FE)) begin
            o_encoding = ENC_UTF16_LE;
        end else if ((r_bytes_seen != 2'd1) && (r_first_byte == BOM16_FE)
                     && (r_second_byte == BOM16_FF)) begin
            o_encoding = ENC_UTF16_BE;
        end else if (!r_saw_high) begin
            o_encoding = ENC_ASCII;
        end else if (!r_broken && (r_pending == 2'd0)) begin
            o_encoding = ENC_UTF8;
        end else begin
            o_encoding = ENC_UNKNOWN;
        end
    end

endmodule

`default_nettype wire

/* src/ted_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module ted_out_reg
    import ted_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [2:0] i_encoding,
    input  wire logic       i_out_stall,
    output logic            o_free,
    output logic            o_out_valid,
    output logic      [2:0] o_encoding
);

    logic       r_valid;
    logic [2:0] r_encoding;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_encoding  = r_encoding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_encoding <= i_encoding;
        end
    end

endmodule

`default_nettype wire

/* src/text_encoding_detector_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Detects the text encoding of a byte buffer streamed in one byte per transfer and closed by
// an end transfer, which yields one verdict code; the detector then clears for the next buffer.
// One input transfer is taken every cycle while the input side is not stalled. Each transfer
// passes an input register; a data byte then updates the scan flags and counters, and an end
// transfer loads its verdict into the output register. The input side stalls only while an end
// transfer waits behind a result that the output side is stalling.

module text_encoding_detector_core
    import ted_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_byte_value,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [2:0] o_encoding
);

    logic       r_in_valid;
    logic       r_cmd;
    logic [7:0] r_byte_value;
    logic       out_free;
    logic       advance;
    t_step      step;
    logic [2:0] verdict;

    assign advance     = r_in_valid && ((r_cmd == CMD_DATA) || out_free);
    assign o_in_stall  = r_in_valid && !advance;
    assign step.take   = advance && (r_cmd == CMD_DATA);
    assign step.finish = advance && (r_cmd == CMD_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd        <= i_cmd;
            r_byte_value <= i_byte_value;
        end
    end

    ted_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte_value (r_byte_value),
        .o_encoding   (verdict)
    );

    ted_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step.finish),
        .i_encoding  (verdict),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_encoding  (o_encoding)
    );

endmodule

`default_nettype wire

/* src/ted_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "text_encoding_detector_core_assert.svh"

module ted_checker
    import ted_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_cmd,
    input wire logic [7:0] i_byte_value,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_encoding
);

    `TED_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_encoding))
    `TED_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_cmd) && $stable(i_byte_value))
    `TED_ASSERT_IMP(a_code_range, o_out_valid, o_encoding <= ENC_UNKNOWN)
    `TED_ASSERT_IMP(a_stall_cause, o_in_stall, i_out_stall && o_out_valid)
    `TED_ASSERT_NEXT_ALWAYS(a_reset_idle, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind text_encoding_detector_core ted_checker u_ted_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_cmd        (i_cmd),
    .i_byte_value (i_byte_value),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_encoding   (o_encoding)
);

`default_nettype wire

/* tb/tb_text_encoding_detector_core.sv */
`timescale 1ns / 1ps

module tb_text_encoding_detector_core;

    import ted_pkg::*;

    typedef struct packed {
        logic       cmd;
        logic [7:0] value;
    } t_stim;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] lead0;
        logic [7:0] lead1;
        logic       bom8;
        logic       high;
        logic       broken;
        logic [1:0] owed;
    } t_scan;

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       i_cmd        = CMD_DATA;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_encoding;

    t_stim      stim_q[$];
    logic [2:0] encoding_due[$];
    t_scan      scan = '0;
    t_stim      next_item;
    logic [2:0] want;
    bit         in_sent   = 1'b0;
    int         in_gap    = 0;
    int         out_gap   = 0;
    int         fail_count = 0;

    text_encoding_detector_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_byte_value (i_byte_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_encoding   (o_encoding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic absorb_byte(input logic [7:0] b);
        if (scan.count == 2'd0) begin
            scan.lead0 = b;
        end else if (scan.count == 2'd1) begin
            scan.lead1 = b;
        end else if (scan.count == 2'd2) begin
            scan.bom8 = (scan.lead0 == BOM8_B0) && (scan.lead1 == BOM8_B1) && (b == BOM8_B2);
        end
        if (scan.count != 2'd3) begin
            scan.count = scan.count + 2'd1;
        end
        if (b > BYTE_ASCII_MAX) begin
            scan.high = 1'b1;
        end
        if (scan.owed != 2'd0) begin
            if ((b & MASK_TOP2) != PAT_CONT) begin
                scan.broken = 1'b1;
            end
            scan.owed = scan.owed - 2'd1;
        end else if (b <= BYTE_ASCII_MAX) begin
        end else if ((b & MASK_TOP3) == PAT_LEAD2) begin
            scan.owed = 2'd1;
        end else if ((b & MASK_TOP4) == PAT_LEAD3) begin
            scan.owed = 2'd2;
        end else if ((b & MASK_TOP5) == PAT_LEAD4) begin
            scan.owed = 2'd3;
        end else begin
            scan.broken = 1'b1;
        end
    endtask

    function automatic logic [2:0] judge_encoding(input t_scan s);
        if (s.count == 2'd0) begin
            return ENC_UTF8;
        end
        if (s.bom8) begin
            return ENC_UTF8_BOM;
        end
        if (s.count >= 2'd2) begin
            if (s.lead0 == BOM16_FF && s.lead1 == BOM16_FE) begin
                return ENC_UTF16_LE;
            end
            if (s.lead0 == BOM16_FE && s.lead1 == BOM16_FF) begin
                return ENC_UTF16_BE;
            end
        end
        if (!s.high) begin
            return ENC_ASCII;
        end
        if (!s.broken && s.owed == 2'd0) begin
            return ENC_UTF8;
        end
        return ENC_UNKNOWN;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        stim_q.push_back('{cmd: CMD_DATA, value: b});
    endtask

    task automatic push_end();
        stim_q.push_back('{cmd: CMD_END, value: 8'($urandom_range(0, 255))});
    endtask

    task automatic push_char(ref logic [7:0] chunk[$]);
        int k;
        int extra;
        k = $urandom_range(0, 3);
        extra = k;
        case (k)
            0: chunk.push_back(8'($urandom_range(0, 127)));
            1: chunk.push_back(PAT_LEAD2 | 8'($urandom_range(0, 31)));
            2: chunk.push_back(PAT_LEAD3 | 8'($urandom_range(0, 15)));
            default: chunk.push_back(PAT_LEAD4 | 8'($urandom_range(0, 7)));
        endcase
        repeat (extra) chunk.push_back(PAT_CONT | 8'($urandom_range(0, 63)));
    endtask

    task automatic make_buffer();
        logic [7:0] chunk[$];
        int style;
        int len;
        style = $urandom_range(0, 9);
        len = $urandom_range(0, 8);
        case (style)
            0: begin
                chunk.push_back(BOM8_B0);
                chunk.push_back(BOM8_B1);
                chunk.push_back(BOM8_B2);
                repeat (len) push_char(chunk);
            end
            1: begin
                chunk.push_back(BOM16_FF);
                chunk.push_back(BOM16_FE);
                repeat (len) chunk.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
                chunk.push_back(BOM16_FE);
                chunk.push_back(BOM16_FF);
                repeat (len) chunk.push_back(8'($urandom_range(0, 255)));
            end
            3: repeat (len + 1) chunk.push_back(8'($urandom_range(0, 127)));
            4: repeat ($urandom_range(1, 6)) chunk.push_back(8'($urandom_range(0, 255)));
            default: repeat (len) push_char(chunk);
        endcase
        if (chunk.size() != 0 && $urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                chunk[$urandom_range(0, chunk.size() - 1)] = 8'($urandom_range(0, 255));
            end else begin
                void'(chunk.pop_back());
            end
        end
        foreach (chunk[i]) push_byte(chunk[i]);
        push_end();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (encoding_due.size() == 0) begin
                    $error("encoding: unexpected result, actual %0d", o_encoding);
                    fail_count++;
                end else begin
                    want = encoding_due.pop_front();
                    if (o_encoding !== want) begin
                        $error("encoding mismatch: expected %0d, actual %0d", want, o_encoding);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                in_sent = 1'b1;
                if (i_cmd == CMD_END) begin
                    encoding_due.push_back(judge_encoding(scan));
                    scan = '0;
                end else begin
                    absorb_byte(i_byte_value);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_sent) begin
                in_sent = 1'b0;
                if (in_gap != 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (stim_q.size() != 0) begin
                    next_item = stim_q.pop_front();
                    i_cmd        <= next_item.cmd;
                    i_byte_value <= next_item.value;
                    i_in_valid   <= 1'b1;
                    if (stim_q.size() > 300 && $urandom_range(0, 6) == 0) begin
                        in_gap = $urandom_range(1, 11);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (out_gap != 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (stim_q.size() > 300 && $urandom_range(0, 5) == 0) begin
                    out_gap = $urandom_range(1, 11);
                end
            end
        end
    end

    initial begin
        push_end();
        push_byte(BOM8_B0); push_byte(BOM8_B1); push_byte(BOM8_B2); push_end();
        push_byte(BOM16_FF); push_byte(BOM16_FE); push_end();
        push_byte(BOM16_FE); push_byte(BOM16_FF); push_end();
        push_byte(8'h00); push_byte(BYTE_ASCII_MAX); push_end();
        push_byte(8'hF0); push_byte(8'h90); push_byte(8'h80); push_byte(8'hBF); push_end();
        push_byte(8'hE2); push_byte(8'h82); push_end();
        push_byte(8'hC3); push_byte(8'h41); push_byte(8'hF8); push_byte(8'h80); push_end();
        while (stim_q.size() < 1800) begin
            make_buffer();
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_in_valid || encoding_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
